FILE: design/sbcc_pkg.sv
// Shared types, constants and helpers for the sprite blitter.
package sbcc_pkg;

    localparam int PIX_W      = 16;
    localparam int ADDR_W     = 22;
    localparam int DIM_W      = 12;
    localparam int POS_W      = 13;
    localparam int COORD_W    = 15;
    localparam int PROD_W     = 2 * DIM_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] ALIGN_MID = 2'd1;
    localparam logic [1:0] ALIGN_END = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEST_X,
        CFG_DEST_Y,
        CFG_SPRITE_WIDTH,
        CFG_SPRITE_HEIGHT,
        CFG_ALIGN_MODE,
        CFG_SCREEN_WIDTH,
        CFG_SCREEN_HEIGHT,
        CFG_KEY_ENABLE
    } cfg_index_t;

    typedef struct packed {
        logic signed [POS_W-1:0] dest_x;
        logic signed [POS_W-1:0] dest_y;
        logic [DIM_W-1:0]        sprite_width;
        logic [DIM_W-1:0]        sprite_height;
        logic [1:0]              align_mode;
        logic [DIM_W-1:0]        screen_width;
        logic [DIM_W-1:0]        screen_height;
        logic                    key_enable;
    } cfg_t;

    typedef struct packed {
        logic             write_en;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
        logic [PIX_W-1:0] pixel;
        logic             done;
    } item_t;

    function automatic logic [DIM_W-1:0] clamp_dim(
        input logic [DIM_W-1:0] v,
        input logic             zero_to_one,
        input logic [DIM_W:0]   max_dim
    );
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0 && zero_to_one) begin
            r = DIM_W'(1);
        end else if ({1'b0, v} > max_dim) begin
            r = max_dim[DIM_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: design/sbcc_front.sv
// Front end: pixel counters, screen position, clipping and color-key classification.
module sbcc_front #(
    parameter int MAX_DIM   = 2048,
    parameter int KEY_COLOR = 2016
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  sbcc_pkg::cfg_t              cfg,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [sbcc_pkg::PIX_W-1:0]  s_pixel_in,
    input  logic                        q_ready,
    output logic                        q_push,
    output sbcc_pkg::item_t             q_item
);

    localparam int CW = $clog2(MAX_DIM);
    localparam logic [sbcc_pkg::DIM_W:0] MAX_DIM_C = (sbcc_pkg::DIM_W + 1)'(MAX_DIM);
    localparam logic [sbcc_pkg::PIX_W-1:0] KEY_C = sbcc_pkg::PIX_W'(KEY_COLOR);

    logic [CW-1:0]                  col_reg, col_next;
    logic [CW-1:0]                  row_reg, row_next;
    logic [sbcc_pkg::DIM_W-1:0]     w, h, sw, sh, x_off;
    logic signed [sbcc_pkg::COORD_W-1:0] x0, scol, srow;
    logic                           on_screen, keyed, last_col, last_row, accept;

    assign s_ready = q_ready;
    assign accept  = s_valid && q_ready;
    assign q_push  = accept;

    always_comb begin
        w  = sbcc_pkg::clamp_dim(cfg.sprite_width, 1'b1, MAX_DIM_C);
        h  = sbcc_pkg::clamp_dim(cfg.sprite_height, 1'b1, MAX_DIM_C);
        sw = sbcc_pkg::clamp_dim(cfg.screen_width, 1'b0, MAX_DIM_C);
        sh = sbcc_pkg::clamp_dim(cfg.screen_height, 1'b0, MAX_DIM_C);

        unique case (cfg.align_mode)
            sbcc_pkg::ALIGN_MID: x_off = w >> 1;
            sbcc_pkg::ALIGN_END: x_off = w;
            default:             x_off = '0;
        endcase

        x0   = $signed({{2{cfg.dest_x[12]}}, cfg.dest_x})
             - $signed(sbcc_pkg::COORD_W'(x_off));
        scol = x0 + $signed(sbcc_pkg::COORD_W'(col_reg));
        srow = $signed({{2{cfg.dest_y[12]}}, cfg.dest_y})
             + $signed(sbcc_pkg::COORD_W'(h))
             - $signed(sbcc_pkg::COORD_W'(1))
             - $signed(sbcc_pkg::COORD_W'(row_reg));

        on_screen = !scol[sbcc_pkg::COORD_W-1]
                 && (scol[sbcc_pkg::COORD_W-2:0] < (sbcc_pkg::COORD_W-1)'(sw))
                 && !srow[sbcc_pkg::COORD_W-1]
                 && (srow[sbcc_pkg::COORD_W-2:0] < (sbcc_pkg::COORD_W-1)'(sh));
        keyed = cfg.key_enable && (s_pixel_in == KEY_C);

        last_col = ((sbcc_pkg::DIM_W + 1)'(col_reg) + (sbcc_pkg::DIM_W + 1)'(1)) >= {1'b0, w};
        last_row = ((sbcc_pkg::DIM_W + 1)'(row_reg) + (sbcc_pkg::DIM_W + 1)'(1)) >= {1'b0, h};

        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + CW'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end

        q_item.write_en = on_screen && !keyed;
        q_item.row      = srow[sbcc_pkg::DIM_W-1:0];
        q_item.col      = scol[sbcc_pkg::DIM_W-1:0];
        q_item.pixel    = s_pixel_in;
        q_item.done     = last_col && last_row;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

`ifndef SYNTH
    a_wrap_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && q_item.done |=> col_reg == '0 && row_reg == '0)
        else $error("counters not cleared after last pixel");
`endif

endmodule

FILE: design/sbcc_queue.sv
// Short queue of classified pixels between front and back.
module sbcc_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  sbcc_pkg::item_t push_item,
    output logic            q_ready,
    input  logic            pop,
    output logic            q_valid,
    output sbcc_pkg::item_t pop_item
);

    localparam int DEPTH = sbcc_pkg::QUEUE_DEPTH;
    localparam int PW    = sbcc_pkg::QUEUE_PTR_W;
    localparam int NW    = sbcc_pkg::QUEUE_CNT_W;

    sbcc_pkg::item_t mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0]   count_reg, count_next;

    assign q_ready  = count_reg != NW'(DEPTH);
    assign q_valid  = count_reg != '0;
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + NW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> count_reg < NW'(DEPTH) && wr_ptr_reg != rd_ptr_reg || count_reg == '0)
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("queue underflow");
`endif

endmodule

FILE: design/sbcc_back.sv
// Back end: address multiply, address add and output register.
module sbcc_back #(
    parameter int MAX_DIM = 2048
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [sbcc_pkg::DIM_W-1:0]  screen_width,
    input  logic                        q_valid,
    input  sbcc_pkg::item_t             q_item,
    output logic                        q_pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_write_en,
    output logic [sbcc_pkg::ADDR_W-1:0] m_pixel_addr,
    output logic [sbcc_pkg::PIX_W-1:0]  m_pixel_out,
    output logic                        m_sprite_done
);

    localparam logic [sbcc_pkg::DIM_W:0] MAX_DIM_C = (sbcc_pkg::DIM_W + 1)'(MAX_DIM);

    logic [sbcc_pkg::DIM_W-1:0]  sw;
    logic                        out_ready, s1_ready;
    logic                        s1_valid_reg;
    sbcc_pkg::item_t             s1_item_reg;
    logic [sbcc_pkg::PROD_W-1:0] prod_reg;
    logic [sbcc_pkg::PROD_W-1:0] addr_sum;
    logic                        m_valid_reg, m_write_en_reg, m_sprite_done_reg;
    logic [sbcc_pkg::ADDR_W-1:0] m_pixel_addr_reg;
    logic [sbcc_pkg::PIX_W-1:0]  m_pixel_out_reg;

    assign sw        = sbcc_pkg::clamp_dim(screen_width, 1'b0, MAX_DIM_C);
    assign out_ready = !m_valid_reg || m_ready;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign q_pop     = q_valid && s1_ready;
    assign addr_sum  = prod_reg + sbcc_pkg::PROD_W'(s1_item_reg.col);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= q_valid;
            end
            if (out_ready) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            s1_item_reg <= q_item;
            prod_reg    <= q_item.row * sw;
        end
        if (out_ready && s1_valid_reg) begin
            m_write_en_reg    <= s1_item_reg.write_en;
            m_pixel_addr_reg  <= s1_item_reg.write_en ? addr_sum[sbcc_pkg::ADDR_W-1:0] : '0;
            m_pixel_out_reg   <= s1_item_reg.pixel;
            m_sprite_done_reg <= s1_item_reg.done;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_write_en    = m_write_en_reg;
    assign m_pixel_addr  = m_pixel_addr_reg;
    assign m_pixel_out   = m_pixel_out_reg;
    assign m_sprite_done = m_sprite_done_reg;

`ifndef SYNTH
    a_skip_zero_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_write_en |-> m_pixel_addr == '0)
        else $error("skipped beat carries nonzero address");
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !out_ready |=> s1_valid_reg && $stable(prod_reg))
        else $error("stage one lost while stalled");
`endif

endmodule

FILE: design/sprite_blit_clip_colorkey.sv
// An accepted beat goes through the queue, stage one and the output register.
// Throughput: one pixel per clock; the front takes a beat whenever the two-entry
// queue has room, so a stalled output does not stop intake until the queue fills.
// The address path is one 12x12 multiply stage followed by one add stage.
// Reset (aresetn, synchronous, active low) clears counters, queue and valid flags,
// and loads the configuration registers with their defaults.
module sprite_blit_clip_colorkey #(
    parameter int MAX_DIM   = 2048,
    parameter int KEY_COLOR = 2016
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [sbcc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sbcc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [sbcc_pkg::PIX_W-1:0]       s_pixel_in,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_write_en,
    output logic [sbcc_pkg::ADDR_W-1:0]      m_pixel_addr,
    output logic [sbcc_pkg::PIX_W-1:0]       m_pixel_out,
    output logic                             m_sprite_done
);

    sbcc_pkg::cfg_t  cfg_reg;
    sbcc_pkg::item_t front_item, queue_item;
    logic            q_push, q_ready, q_pop, q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dest_x        <= '0;
            cfg_reg.dest_y        <= '0;
            cfg_reg.sprite_width  <= sbcc_pkg::DIM_W'(1);
            cfg_reg.sprite_height <= sbcc_pkg::DIM_W'(1);
            cfg_reg.align_mode    <= '0;
            cfg_reg.screen_width  <= sbcc_pkg::DIM_W'(1024);
            cfg_reg.screen_height <= sbcc_pkg::DIM_W'(768);
            cfg_reg.key_enable    <= 1'b1;
        end else if (cfg_we) begin
            unique case (sbcc_pkg::cfg_index_t'(cfg_index))
                sbcc_pkg::CFG_DEST_X:        cfg_reg.dest_x        <= $signed(cfg_wdata);
                sbcc_pkg::CFG_DEST_Y:        cfg_reg.dest_y        <= $signed(cfg_wdata);
                sbcc_pkg::CFG_SPRITE_WIDTH:  cfg_reg.sprite_width  <= cfg_wdata[11:0];
                sbcc_pkg::CFG_SPRITE_HEIGHT: cfg_reg.sprite_height <= cfg_wdata[11:0];
                sbcc_pkg::CFG_ALIGN_MODE:    cfg_reg.align_mode    <= cfg_wdata[1:0];
                sbcc_pkg::CFG_SCREEN_WIDTH:  cfg_reg.screen_width  <= cfg_wdata[11:0];
                sbcc_pkg::CFG_SCREEN_HEIGHT: cfg_reg.screen_height <= cfg_wdata[11:0];
                sbcc_pkg::CFG_KEY_ENABLE:    cfg_reg.key_enable    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    sbcc_front #(
        .MAX_DIM   (MAX_DIM),
        .KEY_COLOR (KEY_COLOR)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_pixel_in (s_pixel_in),
        .q_ready    (q_ready),
        .q_push     (q_push),
        .q_item     (front_item)
    );

    sbcc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (front_item),
        .q_ready   (q_ready),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .pop_item  (queue_item)
    );

    sbcc_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .screen_width  (cfg_reg.screen_width),
        .q_valid       (q_valid),
        .q_item        (queue_item),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_write_en    (m_write_en),
        .m_pixel_addr  (m_pixel_addr),
        .m_pixel_out   (m_pixel_out),
        .m_sprite_done (m_sprite_done)
    );

endmodule

FILE: tb/sprite_blit_clip_colorkey_tb.sv
// Testbench for sprite_blit_clip_colorkey: directed and random pixel beats checked against a built-in predictor.
module sprite_blit_clip_colorkey_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DIM_MAX     = 2048;
    localparam logic [15:0] KEY_RGB     = 16'h07E0;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          HOLD_CYCLES = 300;

    typedef struct packed {
        logic                        write_en;
        logic [sbcc_pkg::ADDR_W-1:0] addr;
        logic [sbcc_pkg::PIX_W-1:0]  pixel;
        logic                        done;
    } blit_write_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [sbcc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [sbcc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic [sbcc_pkg::PIX_W-1:0]      s_pixel_in = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic                            m_write_en;
    logic [sbcc_pkg::ADDR_W-1:0]     m_pixel_addr;
    logic [sbcc_pkg::PIX_W-1:0]      m_pixel_out;
    logic                            m_sprite_done;

    // shadow registers
    int dest_x_r = 0;
    int dest_y_r = 0;
    int spr_w_r  = 1;
    int spr_h_r  = 1;
    int align_r  = 0;
    int scr_w_r  = 1024;
    int scr_h_r  = 768;
    int key_en_r = 1;

    // sprite position counters
    int col_pos = 0;
    int row_pos = 0;

    logic [sbcc_pkg::PIX_W-1:0] pixels_pending[$];
    blit_write_t                writes_due[$];

    int  mismatches = 0;
    int  beats_out = 0;
    int  cycle_cnt = 0;
    int  pixels_sent = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    logic hold_req = 1'b0;
    logic no_idle = 1'b0;

    sprite_blit_clip_colorkey dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_in    (s_pixel_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_write_en    (m_write_en),
        .m_pixel_addr  (m_pixel_addr),
        .m_pixel_out   (m_pixel_out),
        .m_sprite_done (m_sprite_done)
    );

    always #10 aclk = ~aclk;

    function automatic int fit_dim(int v, bit zero_to_one);
        if (v == 0 && zero_to_one) begin
            return 1;
        end
        return (v > DIM_MAX) ? DIM_MAX : v;
    endfunction

    function automatic blit_write_t blit_pixel(logic [sbcc_pkg::PIX_W-1:0] pix);
        int          w;
        int          h;
        int          sw;
        int          sh;
        int          x0;
        int          scol;
        int          srow;
        int          lin;
        bit          on_scr;
        bit          last_col;
        bit          last_row;
        blit_write_t r;
        w  = fit_dim(spr_w_r, 1'b1);
        h  = fit_dim(spr_h_r, 1'b1);
        sw = fit_dim(scr_w_r, 1'b0);
        sh = fit_dim(scr_h_r, 1'b0);
        x0 = dest_x_r;
        if (align_r == sbcc_pkg::ALIGN_MID) begin
            x0 = x0 - w / 2;
        end else if (align_r == sbcc_pkg::ALIGN_END) begin
            x0 = x0 - w;
        end
        scol = x0 + col_pos;
        srow = dest_y_r + h - 1 - row_pos;
        on_scr = scol >= 0 && scol < sw && srow >= 0 && srow < sh;
        r.write_en = on_scr && !(key_en_r != 0 && pix == KEY_RGB);
        lin = srow * sw + scol;
        r.addr = r.write_en ? lin[sbcc_pkg::ADDR_W-1:0] : '0;
        r.pixel = pix;
        last_col = col_pos + 1 >= w;
        last_row = row_pos + 1 >= h;
        r.done = last_col && last_row;
        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
        return r;
    endfunction

    task automatic write_reg(sbcc_pkg::cfg_index_t idx,
                             logic [sbcc_pkg::CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            sbcc_pkg::CFG_DEST_X:        dest_x_r = $signed(data);
            sbcc_pkg::CFG_DEST_Y:        dest_y_r = $signed(data);
            sbcc_pkg::CFG_SPRITE_WIDTH:  spr_w_r  = data[sbcc_pkg::DIM_W-1:0];
            sbcc_pkg::CFG_SPRITE_HEIGHT: spr_h_r  = data[sbcc_pkg::DIM_W-1:0];
            sbcc_pkg::CFG_ALIGN_MODE:    align_r  = data[1:0];
            sbcc_pkg::CFG_SCREEN_WIDTH:  scr_w_r  = data[sbcc_pkg::DIM_W-1:0];
            sbcc_pkg::CFG_SCREEN_HEIGHT: scr_h_r  = data[sbcc_pkg::DIM_W-1:0];
            sbcc_pkg::CFG_KEY_ENABLE:    key_en_r = data[0];
            default: ;
        endcase
    endtask

    task automatic program_regs(int dx, int dy, int w, int h, int al, int scw, int sch,
                                int key);
        write_reg(sbcc_pkg::CFG_DEST_X, dx[sbcc_pkg::CFG_DATA_W-1:0]);
        write_reg(sbcc_pkg::CFG_DEST_Y, dy[sbcc_pkg::CFG_DATA_W-1:0]);
        write_reg(sbcc_pkg::CFG_SPRITE_WIDTH, w[sbcc_pkg::CFG_DATA_W-1:0]);
        write_reg(sbcc_pkg::CFG_SPRITE_HEIGHT, h[sbcc_pkg::CFG_DATA_W-1:0]);
        write_reg(sbcc_pkg::CFG_ALIGN_MODE, al[sbcc_pkg::CFG_DATA_W-1:0]);
        write_reg(sbcc_pkg::CFG_SCREEN_WIDTH, scw[sbcc_pkg::CFG_DATA_W-1:0]);
        write_reg(sbcc_pkg::CFG_SCREEN_HEIGHT, sch[sbcc_pkg::CFG_DATA_W-1:0]);
        write_reg(sbcc_pkg::CFG_KEY_ENABLE, key[sbcc_pkg::CFG_DATA_W-1:0]);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_regs();
        int mode;
        int scw;
        int sch;
        mode = $urandom_range(0, 9);
        if (mode == 0) begin
            program_regs($urandom_range(0, 8191), $urandom_range(0, 8191),
                         $urandom_range(0, 4095), $urandom_range(0, 4095),
                         $urandom_range(0, 3), $urandom_range(0, 4095),
                         $urandom_range(0, 4095), $urandom_range(0, 1));
        end else if (mode == 1) begin
            // near the far corner of a big screen
            program_regs($urandom_range(1990, 2050), $urandom_range(1990, 2050),
                         $urandom_range(1, 8), $urandom_range(1, 8),
                         $urandom_range(0, 3), $urandom_range(1900, 4095),
                         $urandom_range(1900, 4095), $urandom_range(0, 1));
        end else begin
            scw = $urandom_range(0, 40);
            sch = $urandom_range(0, 40);
            program_regs(int'($urandom_range(0, scw + 16)) - 8,
                         int'($urandom_range(0, sch + 16)) - 8,
                         $urandom_range(0, 6), $urandom_range(0, 5),
                         $urandom_range(0, 3), scw, sch, $urandom_range(0, 3) != 0);
        end
    endtask

    task automatic send_pixels(int n);
        for (int i = 0; i < n; i++) begin
            pixels_pending.push_back(($urandom_range(0, 3) == 0) ? KEY_RGB
                                                                 : 16'($urandom_range(0, 65535)));
        end
        pixels_sent += n;
    endtask

    task automatic drain();
        do begin
            @(posedge aclk);
        end while (pixels_pending.size() != 0 || s_valid || writes_due.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic note_mismatch(string field, int unsigned want, int unsigned got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch beat %0d %s: expected %0h, got %0h", beats_out, field, want, got);
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                writes_due.push_back(blit_pixel(s_pixel_in));
            end
            if (!s_valid || s_ready) begin
                if (pixels_pending.size() != 0 && (no_idle || $urandom_range(99) >= 20)) begin
                    s_valid    <= 1'b1;
                    s_pixel_in <= pixels_pending.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result-side backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_ready <= no_idle || ($urandom_range(99) >= 20);
        end
    end

    // monitor
    always @(posedge aclk) begin
        blit_write_t want;
        if (aresetn && m_valid && m_ready) begin
            if (writes_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected beat %0d: addr %0h pixel %0h",
                             beats_out, m_pixel_addr, m_pixel_out);
                end
            end else begin
                want = writes_due.pop_front();
                if (m_write_en !== want.write_en) begin
                    note_mismatch("write_en", want.write_en, m_write_en);
                end
                if (m_pixel_addr !== want.addr) begin
                    note_mismatch("pixel_addr", want.addr, m_pixel_addr);
                end
                if (m_pixel_out !== want.pixel) begin
                    note_mismatch("pixel_out", want.pixel, m_pixel_out);
                end
                if (m_sprite_done !== want.done) begin
                    note_mismatch("sprite_done", want.done, m_sprite_done);
                end
            end
            beats_out++;
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int phase;
        int n;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset geometry: 1x1 sprite, keying on
        pixels_pending.push_back(16'h0000);
        pixels_pending.push_back(16'hFFFF);
        pixels_pending.push_back(KEY_RGB);
        pixels_pending.push_back(KEY_RGB ^ 16'h0001);
        drain();

        // zero sprite size, oversized and zero screen, unused alignment
        program_regs(-4096, 4095, 0, 0, 3, 4095, 0, 0);
        pixels_pending.push_back(KEY_RGB);
        pixels_pending.push_back(16'h5A5A);
        drain();

        // clipped at the right edge of a saturated screen, top address
        program_regs(2046, 2046, 3, 2, 0, 2048, 4095, 0);
        for (int i = 0; i < 6; i++) begin
            pixels_pending.push_back(i[0] ? KEY_RGB : 16'hA5C3 + 16'(i));
        end
        drain();

        // centered, clipped on the left
        program_regs(1, 0, 5, 1, sbcc_pkg::ALIGN_MID, 4, 4, 1);
        for (int i = 0; i < 5; i++) begin
            pixels_pending.push_back(i == 2 ? KEY_RGB : 16'h1234 << i);
        end
        drain();

        // right aligned, oversized sprite; leaves counters mid-row
        program_regs(4095, -4096, 4095, 4095, sbcc_pkg::ALIGN_END, 1024, 768, 1);
        for (int i = 0; i < 3; i++) begin
            pixels_pending.push_back(16'hFFFF - 16'(i));
        end
        drain();

        pixels_sent = 0;
        phase = 0;
        while (pixels_sent < 850) begin
            random_regs();
            if (phase == 2) begin
                no_idle <= 1'b1;
                n = 200;
            end else if (phase == 5) begin
                hold_req <= 1'b1;
                n = 60;
            end else begin
                n = $urandom_range(8, 60);
            end
            send_pixels(n);
            drain();
            no_idle  <= 1'b0;
            hold_req <= 1'b0;
            phase++;
        end

        repeat (10) @(posedge aclk);
        if (mismatches == 0 && writes_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/sbcc_pkg.sv
design/sbcc_front.sv
design/sbcc_queue.sv
design/sbcc_back.sv
design/sprite_blit_clip_colorkey.sv
tb/sprite_blit_clip_colorkey_tb.sv
